@@ hw/rtl/deque_with_search_assert.svh @@
// deque_with_search_assert.svh: assertion macros for the deque block
// depends on clk and rst being visible at the place of use
`ifndef DEQUE_WITH_SEARCH_ASSERT_SVH
`define DEQUE_WITH_SEARCH_ASSERT_SVH

// property that must hold at every edge out of reset
`define DWS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// implication checked in the same cycle
`define DWS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dws_pkg.sv @@
`timescale 1ns / 1ps
// dws_pkg: shared types, constants and ring pointer helpers for the deque block
// no dependencies
package dws_pkg;

  localparam int CAPACITY = 16;
  localparam int PTR_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int OP_W     = 3;
  localparam int QDEPTH   = 2;
  localparam int QAW      = $clog2(QDEPTH);
  localparam int QLVL_W   = $clog2(QDEPTH + 1);

  // request codes on the operation field
  localparam logic [OP_W-1:0] OP_DUMP    = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_F  = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_R  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_F   = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_R   = 3'd4;
  localparam logic [OP_W-1:0] OP_SEARCH  = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    CMD_DUMP,
    CMD_PUSH_F,
    CMD_PUSH_R,
    CMD_POP_F,
    CMD_POP_R,
    CMD_SEARCH,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic signed [VALUE_W-1:0]  value;
  } cmd_t;

  // handoff from the command queue to the execution side
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_POP,
    BK_WALK,
    BK_SFIN
  } bk_state_t;

  // ring slot at base plus offset, modulo capacity
  function automatic logic [PTR_W-1:0] slot_add(input logic [PTR_W-1:0] base,
                                                input logic [PTR_W-1:0] off);
    logic [PTR_W:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (PTR_W+1)'(CAPACITY)) begin
      s = s - (PTR_W+1)'(CAPACITY);
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] slot_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] slot_dec(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == '0) ? PTR_W'(CAPACITY - 1) : p - 1'b1;
    return r;
  endfunction

endpackage

@@ hw/rtl/dws_ram.sv @@
`timescale 1ns / 1ps
// dws_ram: generic single write, single read memory with registered read data
// no dependencies
module dws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/dws_front.sv @@
`timescale 1ns / 1ps
// dws_front: takes request words, decodes them and queues the commands
// depends on dws_pkg
module dws_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dws_pkg::OP_W-1:0]           operation,
  input  logic signed [dws_pkg::VALUE_W-1:0] value,
  output dws_pkg::cmd_head_t                 head,
  input  logic                               take
);

  dws_pkg::cmd_t                 slots [dws_pkg::QDEPTH];
  logic [dws_pkg::QAW-1:0]       wp;
  logic [dws_pkg::QAW-1:0]       rp;
  logic [dws_pkg::QLVL_W-1:0]    level;
  dws_pkg::cmd_t                 dec;
  logic                          push;

  // decode the operation code into a command
  always_comb begin
    dec.value = value;
    case (operation)
      dws_pkg::OP_DUMP:   dec.kind = dws_pkg::CMD_DUMP;
      dws_pkg::OP_PUSH_F: dec.kind = dws_pkg::CMD_PUSH_F;
      dws_pkg::OP_PUSH_R: dec.kind = dws_pkg::CMD_PUSH_R;
      dws_pkg::OP_POP_F:  dec.kind = dws_pkg::CMD_POP_F;
      dws_pkg::OP_POP_R:  dec.kind = dws_pkg::CMD_POP_R;
      dws_pkg::OP_SEARCH: dec.kind = dws_pkg::CMD_SEARCH;
      default:            dec.kind = dws_pkg::CMD_NOP;
    endcase
  end

  // queue flow control
  assign in_stall   = (level == dws_pkg::QLVL_W'(dws_pkg::QDEPTH));
  assign push       = in_valid && !in_stall;
  assign head.valid = (level != '0);
  assign head.cmd   = slots[rp];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= dec;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wp <= (wp == dws_pkg::QAW'(dws_pkg::QDEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (take) begin
        rp <= (rp == dws_pkg::QAW'(dws_pkg::QDEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !take) begin
        level <= level + 1'b1;
      end else if (take && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/dws_back.sv @@
`timescale 1ns / 1ps
// dws_back: executes queued commands on the ring buffer and drives result words
// depends on dws_pkg and dws_ram
module dws_back (
  input  logic                                clk,
  input  logic                                rst,
  input  dws_pkg::cmd_head_t                  head,
  output logic                                take,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dws_pkg::VALUE_W-1:0]  data,
  output logic                                found,
  output logic [1:0]                          status,
  output logic                                is_empty,
  output logic [dws_pkg::CNT_W-1:0]           entry_count,
  output logic                                last,
  output logic [dws_pkg::CNT_W-1:0]           cur_count
);

  localparam logic [dws_pkg::CNT_W-1:0] CAP_CNT = dws_pkg::CNT_W'(dws_pkg::CAPACITY);

  dws_pkg::bk_state_t                 state, state_next;
  dws_pkg::cmd_kind_t                 kind, kind_next;
  logic signed [dws_pkg::VALUE_W-1:0] key, key_next;
  logic [dws_pkg::CNT_W-1:0]          count, count_next;
  logic [dws_pkg::PTR_W-1:0]          front_ptr, front_ptr_next;
  logic [dws_pkg::CNT_W-1:0]          issue_idx, issue_idx_next;
  logic [dws_pkg::CNT_W-1:0]          pend_idx, pend_idx_next;
  logic                               pend, pend_next;
  logic                               hit, hit_next;

  logic                               wr_en, rd_en;
  logic [dws_pkg::PTR_W-1:0]          wr_addr, rd_addr;
  logic [dws_pkg::VALUE_W-1:0]        rd_data;

  logic                               out_free, advance, emit;
  logic signed [dws_pkg::VALUE_W-1:0] e_data;
  logic                               e_found, e_last;
  logic [1:0]                         e_status;

  dws_ram #(
    .WIDTH (dws_pkg::VALUE_W),
    .DEPTH (dws_pkg::CAPACITY)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (head.cmd.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free  = !out_valid || !out_stall;
  assign cur_count = count;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dws_pkg::BK_IDLE;
      count     <= '0;
      front_ptr <= '0;
      pend      <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      front_ptr <= front_ptr_next;
      pend      <= pend_next;
    end
  end

  // command and walk bookkeeping
  always_ff @(posedge clk) begin
    kind      <= kind_next;
    key       <= key_next;
    issue_idx <= issue_idx_next;
    pend_idx  <= pend_idx_next;
    hit       <= hit_next;
  end

  // next state, memory access and result selection
  always_comb begin
    state_next     = state;
    kind_next      = kind;
    key_next       = key;
    count_next     = count;
    front_ptr_next = front_ptr;
    issue_idx_next = issue_idx;
    pend_idx_next  = pend_idx;
    pend_next      = pend;
    hit_next       = hit;
    take           = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = front_ptr;
    rd_en          = 1'b0;
    rd_addr        = front_ptr;
    emit           = 1'b0;
    e_data         = '0;
    e_found        = 1'b0;
    e_status       = dws_pkg::ST_OK;
    e_last         = 1'b1;
    advance        = 1'b0;

    case (state)
      dws_pkg::BK_IDLE: begin
        if (head.valid && out_free) begin
          take      = 1'b1;
          kind_next = head.cmd.kind;
          key_next  = head.cmd.value;
          case (head.cmd.kind)
            dws_pkg::CMD_PUSH_F: begin
              emit = 1'b1;
              if (count == CAP_CNT) begin
                e_status = dws_pkg::ST_FULL;
              end else begin
                wr_en          = 1'b1;
                wr_addr        = dws_pkg::slot_dec(front_ptr);
                front_ptr_next = dws_pkg::slot_dec(front_ptr);
                count_next     = count + 1'b1;
              end
            end
            dws_pkg::CMD_PUSH_R: begin
              emit = 1'b1;
              if (count == CAP_CNT) begin
                e_status = dws_pkg::ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = dws_pkg::slot_add(front_ptr, count[dws_pkg::PTR_W-1:0]);
                count_next = count + 1'b1;
              end
            end
            dws_pkg::CMD_POP_F: begin
              if (count == '0) begin
                emit     = 1'b1;
                e_status = dws_pkg::ST_EMPTY;
              end else begin
                rd_en          = 1'b1;
                rd_addr        = front_ptr;
                front_ptr_next = dws_pkg::slot_inc(front_ptr);
                count_next     = count - 1'b1;
                state_next     = dws_pkg::BK_POP;
              end
            end
            dws_pkg::CMD_POP_R: begin
              if (count == '0) begin
                emit     = 1'b1;
                e_status = dws_pkg::ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                count_next = count - 1'b1;
                rd_addr    = dws_pkg::slot_add(front_ptr,
                                               count_next[dws_pkg::PTR_W-1:0]);
                state_next = dws_pkg::BK_POP;
              end
            end
            dws_pkg::CMD_SEARCH, dws_pkg::CMD_DUMP: begin
              if (count == '0) begin
                emit     = 1'b1;
                e_status = (head.cmd.kind == dws_pkg::CMD_DUMP) ?
                           dws_pkg::ST_EMPTY : dws_pkg::ST_OK;
              end else begin
                issue_idx_next = '0;
                pend_next      = 1'b0;
                hit_next       = 1'b0;
                state_next     = dws_pkg::BK_WALK;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      // popped entry arrives from the memory
      dws_pkg::BK_POP: begin
        if (out_free) begin
          emit       = 1'b1;
          e_data     = rd_data;
          state_next = dws_pkg::BK_IDLE;
        end
      end

      // walk entries front to rear, one read issued per cycle, a dump waiting while its result is stalled
      dws_pkg::BK_WALK: begin
        advance = !pend || (kind != dws_pkg::CMD_DUMP) || out_free;
        if (advance) begin
          if (pend) begin
            if (kind == dws_pkg::CMD_DUMP) begin
              emit   = 1'b1;
              e_data = rd_data;
              e_last = (pend_idx == count - 1'b1);
            end else begin
              hit_next = hit || (rd_data == key);
            end
          end
          if (issue_idx < count) begin
            rd_en          = 1'b1;
            rd_addr        = dws_pkg::slot_add(front_ptr, issue_idx[dws_pkg::PTR_W-1:0]);
            pend_next      = 1'b1;
            pend_idx_next  = issue_idx;
            issue_idx_next = issue_idx + 1'b1;
          end else begin
            pend_next  = 1'b0;
            state_next = (kind == dws_pkg::CMD_DUMP) ? dws_pkg::BK_IDLE :
                                                       dws_pkg::BK_SFIN;
          end
        end
      end

      // search verdict
      dws_pkg::BK_SFIN: begin
        if (out_free) begin
          emit       = 1'b1;
          e_found    = hit;
          state_next = dws_pkg::BK_IDLE;
        end
      end

      default: begin
        state_next = dws_pkg::BK_IDLE;
      end
    endcase
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      data        <= e_data;
      found       <= e_found;
      status      <= e_status;
      is_empty    <= (count_next == '0);
      entry_count <= count_next;
      last        <= e_last;
    end
  end

endmodule

@@ hw/rtl/deque_with_search.sv @@
`timescale 1ns / 1ps
// deque_with_search: top level of the bounded deque with linear search
// depends on dws_pkg, dws_front, dws_back (and dws_ram below it)
//
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------------------------
//   request  | in_valid / in_stall | operation, value
//   result   | out_valid/out_stall | data, found, status, is_empty, entry_count, last
//
// pushes, failed requests, unknown codes and searches or dumps on an empty list
// answer from the idle state, pops after the registered memory read; on a
// non-empty list search and dump walk the single read port of the entry memory
// one slot per cycle (a dump holds while stalled), search then giving its verdict
// a two-word command queue lets requests arrive while the back end is busy
// reset (synchronous) empties the list; entry memory is left as is
// a stalled result holds the back end, the queue keeps taking requests until full
`include "deque_with_search_assert.svh"
module deque_with_search (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dws_pkg::OP_W-1:0]           operation,
  input  logic signed [dws_pkg::VALUE_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [dws_pkg::VALUE_W-1:0] data,
  output logic                               found,
  output logic [1:0]                         status,
  output logic                               is_empty,
  output logic [dws_pkg::CNT_W-1:0]          entry_count,
  output logic                               last
);

  localparam logic [dws_pkg::CNT_W-1:0] CAP_CNT = dws_pkg::CNT_W'(dws_pkg::CAPACITY);

  dws_pkg::cmd_head_t        head;
  logic                      take;
  logic [dws_pkg::CNT_W-1:0] cur_count;
  logic                      full_word;
  logic                      final_ok;

  // request decode and command queue
  dws_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .value     (value),
    .head      (head),
    .take      (take)
  );

  // command execution and result register
  dws_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .take        (take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .data        (data),
    .found       (found),
    .status      (status),
    .is_empty    (is_empty),
    .entry_count (entry_count),
    .last        (last),
    .cur_count   (cur_count)
  );

  // terms used by the checks
  assign full_word = out_valid && (status == dws_pkg::ST_FULL);
  assign final_ok  = last && (status == dws_pkg::ST_OK);

  // checks on the list bookkeeping
  `DWS_ASSERT_ALWAYS(a_count_bound, cur_count <= CAP_CNT, "count above capacity")
  `DWS_ASSERT_IMP(a_empty_flag, out_valid, is_empty == (entry_count == '0), "bad empty flag")
  `DWS_ASSERT_IMP(a_full_status, full_word, entry_count == CAP_CNT, "full status below capacity")
  `DWS_ASSERT_IMP(a_found_single, out_valid && found, final_ok, "found on a non-final word")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for deque_with_search, one word-level predictor of the list
// depends on dws_pkg and the deque_with_search rtl, nothing else
module testbench;
  import dws_pkg::*;

  // codes outside the defined request set
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

  localparam int CYCLE_LIMIT    = 600000;
  localparam int DRAIN_CYCLES   = 2 * CAPACITY + 8;
  localparam int RANDOM_PER_PHASE = 105;
  localparam int DIRECTED_ROWS  = 24;
  localparam int HOLD_STRETCH   = 80;

  typedef struct packed {
    logic signed [VALUE_W-1:0] data;
    logic                      found;
    logic [1:0]                status;
    logic                      is_empty;
    logic [CNT_W-1:0]          entry_count;
    logic                      last;
  } result_t;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] val;
    logic [4:0]                reps;
    logic                      typed;
    result_t                   want;
  } request_row_t;

  localparam result_t NOT_TYPED    = '0;
  localparam result_t EMPTY_REPLY  = '{'0, 1'b0, ST_EMPTY, 1'b1, '0, 1'b1};
  localparam result_t IDLE_REPLY   = '{'0, 1'b0, ST_OK, 1'b1, '0, 1'b1};
  localparam result_t FULL_REPLY   = '{'0, 1'b0, ST_FULL, 1'b0, CNT_W'(CAPACITY), 1'b1};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] operation = OP_DUMP;
  logic signed [VALUE_W-1:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VALUE_W-1:0] data;
  logic found;
  logic [1:0] status;
  logic is_empty;
  logic [CNT_W-1:0] entry_count;
  logic last;

  // predicted list contents
  logic signed [VALUE_W-1:0] model_slots [CAPACITY];
  int unsigned model_front = 0;
  int unsigned model_fill = 0;

  result_t expected_results [$];
  result_t oldest_expected;
  int mismatch_count = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int cycle_count = 0;

  // directed words: typed replies where they are obvious, predictor elsewhere
  // rows with a repeat count above one push random values
  request_row_t directed [0:DIRECTED_ROWS-1] = '{
    '{OP_POP_F,    32'sd0,           5'd1,  1'b1, EMPTY_REPLY},
    '{OP_POP_R,    32'sd0,           5'd1,  1'b1, EMPTY_REPLY},
    '{OP_DUMP,     32'sd0,           5'd1,  1'b1, EMPTY_REPLY},
    '{OP_SEARCH,   32'sd0,           5'd1,  1'b1, IDLE_REPLY},
    '{OP_UNUSED_6, -32'sd1,          5'd1,  1'b1, IDLE_REPLY},
    '{OP_UNUSED_7, 32'sd0,           5'd1,  1'b1, IDLE_REPLY},
    '{OP_PUSH_F,   32'h7fffffff,     5'd1,  1'b1, '{'0, 1'b0, ST_OK, 1'b0, CNT_W'(1), 1'b1}},
    '{OP_PUSH_R,   32'h80000000,     5'd1,  1'b1, '{'0, 1'b0, ST_OK, 1'b0, CNT_W'(2), 1'b1}},
    '{OP_PUSH_F,   -32'sd1,          5'd1,  1'b1, '{'0, 1'b0, ST_OK, 1'b0, CNT_W'(3), 1'b1}},
    '{OP_PUSH_R,   32'sd0,           5'd1,  1'b1, '{'0, 1'b0, ST_OK, 1'b0, CNT_W'(4), 1'b1}},
    '{OP_SEARCH,   32'h7fffffff,     5'd1,  1'b0, NOT_TYPED},
    '{OP_SEARCH,   32'h80000000,     5'd1,  1'b0, NOT_TYPED},
    '{OP_SEARCH,   32'sd12345,       5'd1,  1'b0, NOT_TYPED},
    '{OP_DUMP,     32'sd0,           5'd1,  1'b0, NOT_TYPED},
    '{OP_POP_F,    32'sd0,           5'd1,  1'b0, NOT_TYPED},
    '{OP_POP_R,    32'sd0,           5'd1,  1'b0, NOT_TYPED},
    '{OP_PUSH_R,   32'sd0,           5'd14, 1'b0, NOT_TYPED},
    '{OP_PUSH_F,   32'sd5,           5'd1,  1'b1, FULL_REPLY},
    '{OP_PUSH_R,   -32'sd5,          5'd1,  1'b1, FULL_REPLY},
    '{OP_DUMP,     32'sd0,           5'd1,  1'b0, NOT_TYPED},
    '{OP_SEARCH,   32'h80000000,     5'd1,  1'b0, NOT_TYPED},
    '{OP_POP_R,    32'sd0,           5'd1,  1'b0, NOT_TYPED},
    '{OP_PUSH_F,   32'sd1,           5'd1,  1'b0, NOT_TYPED},
    '{OP_POP_F,    32'sd0,           5'd1,  1'b0, NOT_TYPED}
  };

  deque_with_search dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .data        (data),
    .found       (found),
    .status      (status),
    .is_empty    (is_empty),
    .entry_count (entry_count),
    .last        (last)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ring slot at an offset from the predicted front
  function automatic int unsigned slot_at(input int unsigned off);
    return (model_front + off) % CAPACITY;
  endfunction

  // append one expected word, flags taken from the state after the request
  function automatic void queue_result(input logic signed [VALUE_W-1:0] d, input logic f,
                                       input logic [1:0] st, input logic lst);
    result_t r;
    r.data = d;
    r.found = f;
    r.status = st;
    r.is_empty = (model_fill == 0);
    r.entry_count = CNT_W'(model_fill);
    r.last = lst;
    expected_results.push_back(r);
  endfunction

  // apply one request to the predicted list and queue the words it produces
  function automatic void predict_request(input logic [OP_W-1:0] op,
                                          input logic signed [VALUE_W-1:0] val);
    int unsigned k;
    logic hit;
    logic signed [VALUE_W-1:0] taken;
    hit = 1'b0;
    taken = '0;
    case (op)
      OP_DUMP: begin
        if (model_fill == 0) begin
          queue_result('0, 1'b0, ST_EMPTY, 1'b1);
        end else begin
          for (k = 0; k < model_fill; k++) begin
            queue_result(model_slots[slot_at(k)], 1'b0, ST_OK, k + 1 == model_fill);
          end
        end
      end
      OP_PUSH_F, OP_PUSH_R: begin
        if (model_fill >= CAPACITY) begin
          queue_result('0, 1'b0, ST_FULL, 1'b1);
        end else begin
          if (op == OP_PUSH_F) begin
            model_front = slot_at(CAPACITY - 1);
            model_slots[model_front] = val;
          end else begin
            model_slots[slot_at(model_fill)] = val;
          end
          model_fill++;
          queue_result('0, 1'b0, ST_OK, 1'b1);
        end
      end
      OP_POP_F, OP_POP_R: begin
        if (model_fill == 0) begin
          queue_result('0, 1'b0, ST_EMPTY, 1'b1);
        end else begin
          if (op == OP_POP_F) begin
            taken = model_slots[model_front];
            model_front = slot_at(1);
          end else begin
            taken = model_slots[slot_at(model_fill - 1)];
          end
          model_fill--;
          queue_result(taken, 1'b0, ST_OK, 1'b1);
        end
      end
      OP_SEARCH: begin
        for (k = 0; k < model_fill; k++) begin
          if (model_slots[slot_at(k)] == val) hit = 1'b1;
        end
        queue_result('0, hit, ST_OK, 1'b1);
      end
      default: begin
        queue_result('0, 1'b0, ST_OK, 1'b1);
      end
    endcase
  endfunction

  // random value: small pool for duplicates, extremes, or full range
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r < 2) return VALUE_W'($signed($urandom_range(0, 4)) - 2);
    if (r == 2) return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    return $urandom();
  endfunction

  // offer one request word, hold it until taken, then predict its replies
  task automatic issue_request(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] val,
                               input logic typed, input result_t want);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(op, val);
    if (typed) begin
      void'(expected_results.pop_back());
      expected_results.push_back(want);
    end
  endtask

  // compare one field, x and z count as wrong
  task automatic check_field(input string name, input logic signed [VALUE_W:0] want,
                             input logic signed [VALUE_W:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // stimulus: directed rows, then three phases of random words
  initial begin
    int row;
    int rep;
    int phase;
    int n;
    int unsigned r;
    logic filling;
    logic [OP_W-1:0] op;
    logic signed [VALUE_W-1:0] val;
    filling = 1'b1;
    send_gap_pct = 33;
    recv_stall_pct = 84;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (row = 0; row < DIRECTED_ROWS; row++) begin
      for (rep = 0; rep < directed[row].reps; rep++) begin
        issue_request(directed[row].op,
                      (directed[row].reps > 1) ? $signed($urandom()) : directed[row].val,
                      directed[row].typed, directed[row].want);
      end
    end

    for (phase = 0; phase < 3; phase++) begin
      // sender waits for every outstanding reply before the phase starts
      in_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clk);
      send_gap_pct = (phase == 0) ? 33 : (phase == 1) ? 84 : 0;
      recv_stall_pct = (phase == 0) ? 84 : (phase == 1) ? 33 : 0;
      // long receiver hold-off while words keep coming, so the input backs up
      if (phase == 2) hold_cycles = HOLD_STRETCH;

      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        // swing between filling and draining so both ends are reached often
        if (model_fill == CAPACITY) filling = 1'b0;
        if (model_fill == 0) filling = 1'b1;
        r = $urandom_range(0, 99);
        val = pick_value();
        if (r < 5) begin
          op = OP_DUMP;
        end else if (r < 20) begin
          op = OP_SEARCH;
          if (model_fill > 0 && $urandom_range(0, 1) == 1) begin
            val = model_slots[slot_at($urandom_range(0, model_fill - 1))];
          end
        end else if (r < 23) begin
          op = $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
        end else if (r < (filling ? 73 : 43)) begin
          op = $urandom_range(0, 1) ? OP_PUSH_F : OP_PUSH_R;
        end else begin
          op = $urandom_range(0, 1) ? OP_POP_F : OP_POP_R;
        end
        issue_request(op, val, 1'b0, NOT_TYPED);
      end
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // receiver: random stall, or a counted hold-off when one is requested
  initial begin
    int stretch;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        stretch = hold_cycles;
        hold_cycles = 0;
        out_stall <= 1'b1;
        repeat (stretch) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // result checker: every accepted word against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: word with no expectation, data %0d status %0d last %0b",
                 $time, data, status, last);
        mismatch_count++;
      end else begin
        oldest_expected = expected_results.pop_front();
        check_field("data", oldest_expected.data, data);
        check_field("found", oldest_expected.found, found);
        check_field("status", oldest_expected.status, status);
        check_field("is_empty", oldest_expected.is_empty, is_empty);
        check_field("entry_count", oldest_expected.entry_count, entry_count);
        check_field("last", oldest_expected.last, last);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/dws_pkg.sv
hw/rtl/dws_ram.sv
hw/rtl/dws_front.sv
hw/rtl/dws_back.sv
hw/rtl/deque_with_search.sv
tb/testbench.sv
